// ===== rtl/sfdx_pkg.sv =====
// Package for the serial frame deframer: frame constants, parser phases,
// status and acknowledge codes, and the result record passed between modules.
// No dependencies.
package sfdx_pkg;

    localparam logic [7:0] HDR0     = 8'hFF;
    localparam logic [7:0] HDR1     = 8'hFC;
    localparam logic [7:0] TAIL0    = 8'hA1;
    localparam logic [7:0] TAIL1    = 8'hA2;
    localparam logic [7:0] ID_POSE  = 8'hE0;
    localparam logic [7:0] ID_IMU   = 8'hE1;
    localparam logic [7:0] ID_ACK   = 8'hF0;
    localparam logic [7:0] ACK_POS  = 8'hF2;
    localparam logic [7:0] ACK_NAV  = 8'hF6;
    localparam logic [7:0] ACK_DONE = 8'hF7;

    localparam logic [7:0] ID_LIMIT_RESET     = 8'd241;
    localparam logic [7:0] LENGTH_LIMIT_RESET = 8'd100;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int TDATA_W    = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ID_LIMIT     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SYNC    = 3'd1,
        PH_ID      = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK   = 3'd5,
        PH_TAIL0   = 3'd6,
        PH_TAIL1   = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        ST_POSE    = 3'd0,
        ST_IMU     = 3'd1,
        ST_ACK     = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_BAD_SUM = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ACK_POS_OK  = 2'd0,
        ACK_NAV_OK  = 2'd1,
        ACK_REACHED = 2'd2,
        ACK_OTHER   = 2'd3
    } ack_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t      item_kind;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] frame_kind;
        status_t    frame_status;
        ack_t       ack_code;
        logic       frame_accepted;
    } result_t;

endpackage

// ===== rtl/serial_frame_deframer_xor_top.sv =====
// Top level of the serial frame deframer with XOR checksum.
// Instantiates sfdx_parser and sfdx_out_stage; depends on sfdx_pkg.
//
// One received byte enters per beat on s_, one byte per clock while s_tready is
// high. A byte is parsed in the cycle it is accepted; its result (a payload
// beat, or a status beat at the second tail byte) is registered in the result
// register or the one skid entry behind it on the output, and s_tready drops
// only when both hold results that m_ has not taken. Frame layout: FF FC, id,
// length, payload, XOR checksum, A1 A2. The user must write the id and length
// limits on the cfg_ port only while idle; the block does not enforce this.
module serial_frame_deframer_xor_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] rx_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] payload_byte, [15:8] payload_index, [23:16] frame_kind,
    // [26:24] frame_status, [28:27] ack_code, [29] frame_accepted, [31:30] zero
    output logic [sfdx_pkg::TDATA_W-1:0]     m_tdata,
    output logic                             m_tuser,   // [0] item_kind
    input  logic                             cfg_we,
    input  logic [sfdx_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfdx_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sfdx_pkg::*;

    logic    byte_accept;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign byte_accept = s_tvalid && s_tready;

    sfdx_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .rx_byte     (s_tdata),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .res_valid   (res_valid),
        .res         (res)
    );

    sfdx_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (byte_accept && res_valid),
        .push_data  (res),
        .push_ready (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_res)
    );

    assign m_tuser = out_res.item_kind;
    assign m_tdata = {2'b00, out_res.frame_accepted, out_res.ack_code,
                      out_res.frame_status, out_res.frame_kind,
                      out_res.payload_index, out_res.payload_byte};

endmodule

// ===== rtl/sfdx_parser.sv =====
// Frame parser: phase register, counters, running XOR and the limit registers.
// Forms at most one result per accepted byte. Depends on sfdx_pkg.
module sfdx_parser (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             byte_accept,
    input  logic [7:0]                       rx_byte,
    input  logic                             cfg_we,
    input  logic [sfdx_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfdx_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                             res_valid,
    output sfdx_pkg::result_t                res
);
    import sfdx_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] index_reg, index_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] check_reg, check_next;
    logic [7:0] id_reg, id_next;
    logic [7:0] first_reg, first_next;
    logic [7:0] id_limit_reg;
    logic [7:0] length_limit_reg;
    status_t    status;
    ack_t       ack;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            left_reg         <= '0;
            index_reg        <= '0;
            xor_reg          <= '0;
            check_reg        <= '0;
            id_reg           <= '0;
            first_reg        <= '0;
            id_limit_reg     <= ID_LIMIT_RESET;
            length_limit_reg <= LENGTH_LIMIT_RESET;
        end else begin
            if (byte_accept) begin
                phase_reg <= phase_next;
                left_reg  <= left_next;
                index_reg <= index_next;
                xor_reg   <= xor_next;
                check_reg <= check_next;
                id_reg    <= id_next;
                first_reg <= first_next;
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ID_LIMIT:     id_limit_reg     <= cfg_data;
                    CFG_LENGTH_LIMIT: length_limit_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // frame verdict at the second tail byte
    always_comb begin
        ack = ACK_POS_OK;
        if (check_reg != xor_reg) begin
            status = ST_BAD_SUM;
        end else if (id_reg == ID_POSE) begin
            status = ST_POSE;
        end else if (id_reg == ID_IMU) begin
            status = ST_IMU;
        end else if (id_reg == ID_ACK) begin
            status = ST_ACK;
            case (first_reg)
                ACK_POS:  ack = ACK_POS_OK;
                ACK_NAV:  ack = ACK_NAV_OK;
                ACK_DONE: ack = ACK_REACHED;
                default:  ack = ACK_OTHER;
            endcase
        end else begin
            status = ST_UNKNOWN;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        left_next  = left_reg;
        index_next = index_reg;
        xor_next   = xor_reg;
        check_next = check_reg;
        id_next    = id_reg;
        first_next = first_reg;
        res_valid  = 1'b0;
        res        = '0;
        case (phase_reg)
            PH_IDLE: begin
                if (rx_byte == HDR0) begin
                    phase_next = PH_SYNC;
                    xor_next   = rx_byte;
                end
            end
            PH_SYNC: begin
                if (rx_byte == HDR1) begin
                    phase_next = PH_ID;
                    xor_next   = xor_reg ^ rx_byte;
                end else begin
                    phase_next = PH_IDLE;
                end
            end
            PH_ID: begin
                if (rx_byte < id_limit_reg) begin
                    phase_next = PH_LEN;
                    id_next    = rx_byte;
                    xor_next   = xor_reg ^ rx_byte;
                end else begin
                    phase_next = PH_IDLE;
                end
            end
            PH_LEN: begin
                if (rx_byte < length_limit_reg) begin
                    phase_next = PH_PAYLOAD;
                    left_next  = rx_byte;
                    index_next = '0;
                    xor_next   = xor_reg ^ rx_byte;
                end else begin
                    phase_next = PH_IDLE;
                end
            end
            PH_PAYLOAD: begin
                if (left_reg == '0) begin
                    phase_next = PH_IDLE;
                end else begin
                    res_valid         = 1'b1;
                    res.item_kind     = KIND_PAYLOAD;
                    res.payload_byte  = rx_byte;
                    res.payload_index = index_reg;
                    res.frame_kind    = id_reg;
                    if (index_reg == '0) begin
                        first_next = rx_byte;
                    end
                    xor_next   = xor_reg ^ rx_byte;
                    index_next = index_reg + 8'd1;
                    left_next  = left_reg - 8'd1;
                    if (left_reg == 8'd1) begin
                        phase_next = PH_CHECK;
                    end
                end
            end
            PH_CHECK: begin
                check_next = rx_byte;
                phase_next = PH_TAIL0;
            end
            PH_TAIL0: begin
                phase_next = (rx_byte == TAIL0) ? PH_TAIL1 : PH_IDLE;
            end
            PH_TAIL1: begin
                phase_next = PH_IDLE;
                if (rx_byte == TAIL1) begin
                    res_valid          = 1'b1;
                    res.item_kind      = KIND_STATUS;
                    res.frame_kind     = id_reg;
                    res.frame_status   = status;
                    res.ack_code       = ack;
                    res.frame_accepted = (status == ST_POSE) || (status == ST_IMU);
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    a_payload_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_accept && res_valid && res.item_kind == KIND_PAYLOAD)
            |-> (phase_reg == PH_PAYLOAD && left_reg != '0))
        else $error("payload beat outside payload phase");

    a_status_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_accept && res_valid && res.item_kind == KIND_STATUS)
            |-> (phase_reg == PH_TAIL1 && rx_byte == TAIL1))
        else $error("status beat without complete tail");

    a_last_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_accept && phase_reg == PH_PAYLOAD && left_reg == 8'd1)
            |=> (phase_reg == PH_CHECK))
        else $error("last payload byte did not move to checksum");

endmodule

// ===== rtl/sfdx_out_stage.sv =====
// Result register with a skid entry, so a byte is taken while a result waits.
// Depends on sfdx_pkg.
module sfdx_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  sfdx_pkg::result_t push_data,
    output logic              push_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output sfdx_pkg::result_t out_data
);
    import sfdx_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop        = main_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_data   = main_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                skid_valid_next = push;
                skid_next       = push_data;
            end else begin
                main_valid_next = push;
                main_next       = push_data;
            end
        end else if (push) begin
            if (!main_valid_reg) begin
                main_valid_next = 1'b1;
                main_next       = push_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_next       = push_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held with empty result register");

    a_skid_moves_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && skid_valid_reg) |=> (main_valid_reg && main_reg == $past(skid_reg)))
        else $error("skid entry not promoted on drain");

    a_status_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (main_valid_reg && main_reg.item_kind == KIND_PAYLOAD)
            |-> (main_reg.frame_accepted == 1'b0 && main_reg.ack_code == ACK_POS_OK))
        else $error("payload beat carries status fields");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for serial_frame_deframer_xor_top: byte stream in, payload and
// frame status beats out, checked against an in-bench frame parser model.
// Depends on sfdx_pkg and the deframer RTL only.
module tb_top;
    import sfdx_pkg::*;

    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES   = 300;

    typedef enum int {
        CLEAN     = 0,
        BAD_SYNC  = 1,
        BAD_SUM   = 2,
        BAD_TAIL0 = 3,
        BAD_TAIL1 = 4
    } flaw_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = 8'h00;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tuser;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_ID_LIMIT;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    serial_frame_deframer_xor_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // parser model state and limits
    phase_t     ph       = PH_IDLE;
    logic [7:0] left_cnt = '0;
    logic [7:0] next_idx = '0;
    logic [7:0] sum_x    = '0;
    logic [7:0] rx_sum   = '0;
    logic [7:0] frm_id   = '0;
    logic [7:0] first_b  = '0;
    logic [7:0] lim_id   = ID_LIMIT_RESET;
    logic [7:0] lim_len  = LENGTH_LIMIT_RESET;

    logic [7:0] line_bytes[$];
    result_t    want_items[$];
    int         queued = 0;
    int         fails  = 0;

    bit tx_taken     = 1'b0;
    int tx_gap       = 0;
    int tx_burst     = 0;
    int rx_stall     = 0;
    int rx_burst     = 0;
    int hold_cnt     = 0;
    bit squeeze_req  = 1'b0;
    bit squeeze_done = 1'b0;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic parse_byte(input logic [7:0] b);
        result_t r;
        r = '0;
        case (ph)
            PH_IDLE: begin
                if (b == HDR0) begin
                    ph    = PH_SYNC;
                    sum_x = b;
                end
            end
            PH_SYNC: begin
                if (b == HDR1) begin
                    ph    = PH_ID;
                    sum_x = sum_x ^ b;
                end else begin
                    ph = PH_IDLE;
                end
            end
            PH_ID: begin
                if (b < lim_id) begin
                    ph     = PH_LEN;
                    frm_id = b;
                    sum_x  = sum_x ^ b;
                end else begin
                    ph = PH_IDLE;
                end
            end
            PH_LEN: begin
                if (b < lim_len) begin
                    ph       = PH_PAYLOAD;
                    left_cnt = b;
                    next_idx = '0;
                    sum_x    = sum_x ^ b;
                end else begin
                    ph = PH_IDLE;
                end
            end
            PH_PAYLOAD: begin
                if (left_cnt == 0) begin
                    ph = PH_IDLE;
                end else begin
                    r.item_kind     = KIND_PAYLOAD;
                    r.payload_byte  = b;
                    r.payload_index = next_idx;
                    r.frame_kind    = frm_id;
                    if (next_idx == 0) first_b = b;
                    sum_x    = sum_x ^ b;
                    next_idx = next_idx + 8'd1;
                    left_cnt = left_cnt - 8'd1;
                    if (left_cnt == 0) ph = PH_CHECK;
                    want_items.push_back(r);
                end
            end
            PH_CHECK: begin
                rx_sum = b;
                ph     = PH_TAIL0;
            end
            PH_TAIL0: begin
                ph = (b == TAIL0) ? PH_TAIL1 : PH_IDLE;
            end
            PH_TAIL1: begin
                ph = PH_IDLE;
                if (b == TAIL1) begin
                    r.item_kind    = KIND_STATUS;
                    r.frame_kind   = frm_id;
                    r.ack_code     = ACK_POS_OK;
                    if (rx_sum != sum_x) begin
                        r.frame_status = ST_BAD_SUM;
                    end else if (frm_id == ID_POSE) begin
                        r.frame_status = ST_POSE;
                    end else if (frm_id == ID_IMU) begin
                        r.frame_status = ST_IMU;
                    end else if (frm_id == ID_ACK) begin
                        r.frame_status = ST_ACK;
                        if (first_b == ACK_POS)       r.ack_code = ACK_POS_OK;
                        else if (first_b == ACK_NAV)  r.ack_code = ACK_NAV_OK;
                        else if (first_b == ACK_DONE) r.ack_code = ACK_REACHED;
                        else                          r.ack_code = ACK_OTHER;
                    end else begin
                        r.frame_status = ST_UNKNOWN;
                    end
                    r.frame_accepted = (r.frame_status == ST_POSE) ||
                                       (r.frame_status == ST_IMU);
                    want_items.push_back(r);
                end
            end
            default: ph = PH_IDLE;
        endcase
    endtask

    // sender: model sees each byte as it is taken
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            parse_byte(s_tdata);
            tx_taken = 1'b1;
        end
    end

    always @(negedge aclk) begin : drive_p
        logic v;
        v = s_tvalid && !tx_taken;
        tx_taken = 1'b0;
        if (!v && aresetn) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (line_bytes.size() > 0) begin
                s_tdata <= line_bytes.pop_front();
                v = 1'b1;
                if (tx_burst > 0) begin
                    tx_burst--;
                    tx_gap = 0;
                end else begin
                    tx_gap = gap_len();
                    if ($urandom_range(0, 49) == 0) tx_burst = $urandom_range(20, 80);
                end
            end
        end
        s_tvalid <= v;
    end

    // receiver back-pressure, with one long hold-off on request
    always @(negedge aclk) begin
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else if (squeeze_req && !squeeze_done) begin
            squeeze_done = 1'b1;
            hold_cnt     = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn;
            if (rx_burst > 0) begin
                rx_burst--;
            end else begin
                if ($urandom_range(0, 3) == 0) rx_stall = gap_len();
                if ($urandom_range(0, 49) == 0) rx_burst = $urandom_range(20, 80);
            end
        end
    end

    task automatic check_field(input string nm, input logic [7:0] want,
                               input logic [7:0] seen);
        if (seen !== want) begin
            $error("%s: expected %0h, got %0h", nm, want, seen);
            fails++;
        end
    endtask

    always @(posedge aclk) begin : check_p
        result_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (want_items.size() == 0) begin
                $error("unexpected result beat: tuser %0b tdata %h", m_tuser, m_tdata);
                fails++;
            end else begin
                w = want_items.pop_front();
                check_field("item_kind", 8'(w.item_kind), 8'(m_tuser));
                check_field("payload_byte", w.payload_byte, m_tdata[7:0]);
                check_field("payload_index", w.payload_index, m_tdata[15:8]);
                check_field("frame_kind", w.frame_kind, m_tdata[23:16]);
                check_field("frame_status", 8'(w.frame_status), 8'(m_tdata[26:24]));
                check_field("ack_code", 8'(w.ack_code), 8'(m_tdata[28:27]));
                check_field("frame_accepted", 8'(w.frame_accepted), 8'(m_tdata[29]));
            end
        end
    end

    task automatic put(input logic [7:0] b);
        line_bytes.push_back(b);
        queued++;
    endtask

    task automatic push_frame(input logic [7:0] id, input int len,
                              input logic [7:0] first, input flaw_t fl);
        logic [7:0] x;
        logic [7:0] b;
        int         n;
        put(HDR0);
        put((fl == BAD_SYNC) ? (HDR1 ^ 8'($urandom_range(1, 255))) : HDR1);
        put(id);
        put(8'(len));
        x = HDR0 ^ HDR1 ^ id ^ 8'(len);
        n = (len < int'(lim_len)) ? len : 2;
        for (int i = 0; i < n; i++) begin
            b = (i == 0) ? first : 8'($urandom_range(0, 255));
            put(b);
            x = x ^ b;
        end
        if (fl == BAD_SUM) x = x ^ 8'($urandom_range(1, 255));
        put(x);
        put((fl == BAD_TAIL0) ? (TAIL0 ^ 8'($urandom_range(1, 255))) : TAIL0);
        put((fl == BAD_TAIL1) ? (TAIL1 ^ 8'($urandom_range(1, 255))) : TAIL1);
    endtask

    task automatic random_traffic(input int n);
        int         stop;
        int         r;
        int         len;
        logic [7:0] id;
        logic [7:0] first;
        flaw_t      fl;
        stop = queued + n;
        while (queued < stop) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 7))
                        0:       put(HDR0);
                        1:       put(HDR1);
                        2:       put(TAIL0);
                        3:       put(TAIL1);
                        default: put(8'($urandom_range(0, 255)));
                    endcase
                end
            end else begin
                case ($urandom_range(0, 9))
                    0, 1:    id = ID_POSE;
                    2, 3:    id = ID_IMU;
                    4, 5:    id = ID_ACK;
                    6:       id = lim_id - 8'd1;
                    7:       id = lim_id;
                    default: id = 8'($urandom_range(0, 255));
                endcase
                case ($urandom_range(0, 15))
                    0:       len = 0;
                    1:       len = int'(lim_len);
                    2:       len = (int'(lim_len) > 24) ? $urandom_range(7, 24)
                                                        : int'(lim_len) - 1;
                    3:       len = $urandom_range(7, 24);
                    default: len = $urandom_range(1, 6);
                endcase
                case ($urandom_range(0, 3))
                    0:       first = ACK_POS;
                    1:       first = ACK_NAV;
                    2:       first = ACK_DONE;
                    default: first = 8'($urandom_range(0, 255));
                endcase
                fl = (r < 80) ? CLEAN : flaw_t'($urandom_range(1, 4));
                push_frame(id, len, first, fl);
            end
        end
    endtask

    task automatic settle();
        while (line_bytes.size() != 0 || s_tvalid || want_items.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        if (idx == CFG_ID_LIMIT) lim_id = val;
        else lim_len = val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed frames at the reset limits
        push_frame(ID_POSE, 1, 8'h00, CLEAN);
        push_frame(ID_ACK, 1, ACK_DONE, BAD_SUM);
        push_frame(8'h05, 0, 8'h00, CLEAN);    // zero length, checksum byte aborts
        put(HDR0);
        put(HDR0);                             // second FF dropped, not a new header
        put(HDR0);
        put(HDR1);
        put(8'hF1);                            // id at the limit
        random_traffic(280);
        settle();

        write_reg(CFG_ID_LIMIT, 8'hFF);
        write_reg(CFG_LENGTH_LIMIT, 8'hFF);
        push_frame(ID_IMU, 254, 8'hFF, CLEAN);
        random_traffic(200);
        settle();

        write_reg(CFG_ID_LIMIT, 8'h00);
        write_reg(CFG_LENGTH_LIMIT, 8'h01);
        random_traffic(50);
        settle();

        write_reg(CFG_ID_LIMIT, 8'hFF);
        random_traffic(50);
        settle();

        write_reg(CFG_ID_LIMIT, 8'($urandom_range(8'hE1, 8'hFF)));
        write_reg(CFG_LENGTH_LIMIT, 8'($urandom_range(2, 20)));
        random_traffic(220);
        settle();

        write_reg(CFG_ID_LIMIT, ID_LIMIT_RESET);
        write_reg(CFG_LENGTH_LIMIT, LENGTH_LIMIT_RESET);
        squeeze_req = 1'b1;
        push_frame(ID_POSE, 60, 8'h5A, CLEAN);
        random_traffic(180);
        settle();

        if (fails == 0)
            $display("serial_frame_deframer_xor_top regression: pass");
        else
            $display("serial_frame_deframer_xor_top regression: fail");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("serial_frame_deframer_xor_top regression: fail");
        $finish;
    end

endmodule

// ===== serial_frame_deframer_xor_top.f =====
rtl/sfdx_pkg.sv
rtl/sfdx_parser.sv
rtl/sfdx_out_stage.sv
rtl/serial_frame_deframer_xor_top.sv
bench/tb_top.sv
